>>> sv/vlrs_pkg.sv
// Shared types and constants for the variable-length record deframer.
`default_nettype none

package vlrs_pkg;

  // Parse position inside a record.
  typedef enum logic [1:0] {
    PH_LEN_LO = 2'd0,
    PH_LEN_HI = 2'd1,
    PH_DATA   = 2'd2,
    PH_PAD    = 2'd3
  } phase_t;

  // Terminator selection codes held in the term_mode register.
  localparam logic [1:0] TERM_LF   = 2'd0;
  localparam logic [1:0] TERM_CR   = 2'd1;
  localparam logic [1:0] TERM_CRLF = 2'd2;
  localparam logic [1:0] TERM_NONE = 2'd3;

  localparam logic [7:0] CHAR_NUL = 8'h00;
  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_CR  = 8'h0D;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  // Work request handed from the front to the back.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       emit_data;
    logic       emit_term;
    logic       emit_end;
    logic       end_error;
  } cmd_t;

  // One result item.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       end_of_output;
    logic       format_error;
  } res_t;

endpackage

`default_nettype wire

>>> sv/vlrs_front.sv
// Front part: parses the record framing and turns each byte into a work request.
`default_nettype none

module vlrs_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               accept,
  input  wire logic [7:0]         in_byte,
  input  wire logic               in_last,
  input  wire logic [1:0]         term_mode,
  output vlrs_pkg::cmd_t          cmd,
  output logic                    push
);

  vlrs_pkg::phase_t phase, phase_next, phase_step;
  logic [7:0]  length_low, length_low_next;
  logic [15:0] bytes_remaining, bytes_remaining_next, rem_dec;
  logic        pad_pending, pad_pending_next;
  logic        seen_first_record, seen_first_record_next;

  assign rem_dec = bytes_remaining - 16'd1;

  // Phase after this byte, before the end-of-stream clear.
  always_comb begin
    phase_step = phase;
    unique case (phase)
      vlrs_pkg::PH_LEN_LO: phase_step = vlrs_pkg::PH_LEN_HI;
      vlrs_pkg::PH_LEN_HI: begin
        if ({in_byte, length_low} == 16'd0) begin
          phase_step = vlrs_pkg::PH_LEN_LO;
        end else begin
          phase_step = vlrs_pkg::PH_DATA;
        end
      end
      vlrs_pkg::PH_DATA: begin
        if (rem_dec == 16'd0) begin
          phase_step = pad_pending ? vlrs_pkg::PH_PAD : vlrs_pkg::PH_LEN_LO;
        end
      end
      vlrs_pkg::PH_PAD: phase_step = vlrs_pkg::PH_LEN_LO;
      default: phase_step = vlrs_pkg::PH_LEN_LO;
    endcase
  end

  always_comb begin
    phase_next = phase;
    if (accept) begin
      phase_next = in_last ? vlrs_pkg::PH_LEN_LO : phase_step;
    end
  end

  // Request and data-register updates.
  always_comb begin
    cmd                    = '0;
    cmd.data_byte          = in_byte;
    length_low_next        = length_low;
    bytes_remaining_next   = bytes_remaining;
    pad_pending_next       = pad_pending;
    seen_first_record_next = seen_first_record;
    unique case (phase)
      vlrs_pkg::PH_LEN_LO: length_low_next = in_byte;
      vlrs_pkg::PH_LEN_HI: begin
        bytes_remaining_next   = {in_byte, length_low};
        cmd.emit_term          = seen_first_record;
        seen_first_record_next = 1'b1;
        pad_pending_next       = length_low[0];
      end
      vlrs_pkg::PH_DATA: begin
        cmd.emit_data        = (in_byte != vlrs_pkg::CHAR_NUL);
        bytes_remaining_next = rem_dec;
      end
      vlrs_pkg::PH_PAD: pad_pending_next = 1'b0;
      default: pad_pending_next = 1'b0;
    endcase
    if (in_last) begin
      cmd.emit_end           = 1'b1;
      cmd.end_error          = (phase_step != vlrs_pkg::PH_LEN_LO);
      length_low_next        = 8'd0;
      bytes_remaining_next   = 16'd0;
      pad_pending_next       = 1'b0;
      seen_first_record_next = 1'b0;
    end
  end

  // Requests that would produce no result never enter the queue.
  assign push = accept && (cmd.emit_data || cmd.emit_end ||
                           (cmd.emit_term && (term_mode != vlrs_pkg::TERM_NONE)));

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= vlrs_pkg::PH_LEN_LO;
      length_low        <= 8'd0;
      bytes_remaining   <= 16'd0;
      pad_pending       <= 1'b0;
      seen_first_record <= 1'b0;
    end else if (accept) begin
      phase             <= phase_next;
      length_low        <= length_low_next;
      bytes_remaining   <= bytes_remaining_next;
      pad_pending       <= pad_pending_next;
      seen_first_record <= seen_first_record_next;
    end
  end

endmodule

`default_nettype wire

>>> sv/vlrs_queue.sv
// Small request queue between the front and back parts.
`default_nettype none

module vlrs_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire vlrs_pkg::cmd_t push_cmd,
  input  wire logic           pop,
  output vlrs_pkg::cmd_t      head,
  output logic                empty,
  output logic                full
);

  vlrs_pkg::cmd_t entries [vlrs_pkg::QUEUE_DEPTH];
  logic [vlrs_pkg::QUEUE_AW-1:0] wptr, rptr;
  logic [vlrs_pkg::QUEUE_AW:0]   count;
  logic                          do_push, do_pop;

  assign empty   = (count == '0);
  assign full    = (count == (vlrs_pkg::QUEUE_AW+1)'(vlrs_pkg::QUEUE_DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= wptr + vlrs_pkg::QUEUE_AW'(1);
      end
      if (do_pop) begin
        rptr <= rptr + vlrs_pkg::QUEUE_AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + (vlrs_pkg::QUEUE_AW+1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (vlrs_pkg::QUEUE_AW+1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/vlrs_back.sv
// Back part: expands each request into result items, one per cycle while the output is not stalled.
`default_nettype none

module vlrs_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire vlrs_pkg::cmd_t head,
  input  wire logic           empty,
  input  wire logic [1:0]     term_mode,
  output logic                pop,
  output logic                out_valid,
  input  wire logic           out_stall,
  output vlrs_pkg::res_t      res
);

  vlrs_pkg::res_t items [4];
  logic [2:0] n_items;
  logic [1:0] step;
  logic       load, last_item;

  // Build the list of results for the request at the head of the queue.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      items[i] = '0;
    end
    n_items = 3'd0;
    if (head.emit_data) begin
      items[n_items[1:0]].out_byte   = head.data_byte;
      items[n_items[1:0]].byte_valid = 1'b1;
      n_items = n_items + 3'd1;
    end
    if (head.emit_term && (term_mode != vlrs_pkg::TERM_NONE)) begin
      items[n_items[1:0]].byte_valid = 1'b1;
      items[n_items[1:0]].out_byte   =
          (term_mode == vlrs_pkg::TERM_LF) ? vlrs_pkg::CHAR_LF : vlrs_pkg::CHAR_CR;
      n_items = n_items + 3'd1;
      if (term_mode == vlrs_pkg::TERM_CRLF) begin
        items[n_items[1:0]].byte_valid = 1'b1;
        items[n_items[1:0]].out_byte   = vlrs_pkg::CHAR_LF;
        n_items = n_items + 3'd1;
      end
    end
    if (head.emit_end) begin
      if (head.end_error || (term_mode == vlrs_pkg::TERM_NONE)) begin
        // Bare end marker, carrying the error flag on a ragged end.
        items[n_items[1:0]].end_of_output = 1'b1;
        items[n_items[1:0]].format_error  = head.end_error;
        n_items = n_items + 3'd1;
      end else begin
        items[n_items[1:0]].byte_valid = 1'b1;
        items[n_items[1:0]].out_byte   =
            (term_mode == vlrs_pkg::TERM_LF) ? vlrs_pkg::CHAR_LF : vlrs_pkg::CHAR_CR;
        items[n_items[1:0]].end_of_output = (term_mode != vlrs_pkg::TERM_CRLF);
        n_items = n_items + 3'd1;
        if (term_mode == vlrs_pkg::TERM_CRLF) begin
          items[n_items[1:0]].byte_valid    = 1'b1;
          items[n_items[1:0]].out_byte      = vlrs_pkg::CHAR_LF;
          items[n_items[1:0]].end_of_output = 1'b1;
          n_items = n_items + 3'd1;
        end
      end
    end
  end

  // With a request queued, the output register takes a new item whenever it is empty or being taken.
  assign load      = !empty && (!out_valid || !out_stall);
  assign last_item = ({1'b0, step} + 3'd1 >= n_items);
  assign pop       = load && last_item;

  always_ff @(posedge clk) begin
    if (load) begin
      res <= items[step];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      step      <= 2'd0;
    end else begin
      if (load) begin
        out_valid <= (n_items != 3'd0);
        step      <= last_item ? 2'd0 : step + 2'd1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/vl_record_to_stream_converter.sv
// Top level of the variable-length record deframer.
//
// Takes one file byte per cycle and emits the text bytes of the records, with
// the selected terminator between records and at the end of the stream. A
// byte that produces one result or none passes at one byte per cycle while
// the output is not stalled; a byte that produces several results (terminators,
// end markers) occupies the output register for each result in turn, up to
// four. A four-entry request queue between the framing parser and the result
// expander absorbs such bursts, so input is stalled only when the queue fills.
// Through an empty queue a byte is queued, then its first result registered.
`default_nettype none

module vl_record_to_stream_converter (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            byte_valid,
  output logic            end_of_output,
  output logic            format_error,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_data
);

  logic [1:0]     term_mode;
  logic           accept, push, pop, empty, full;
  vlrs_pkg::cmd_t cmd, head;
  vlrs_pkg::res_t res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      term_mode <= vlrs_pkg::TERM_LF;
    end else if (cfg_valid && cfg_ready) begin
      term_mode <= cfg_data;
    end
  end

  assign in_stall = full;
  assign accept   = in_valid && !in_stall;

  vlrs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .term_mode (term_mode),
    .cmd       (cmd),
    .push      (push)
  );

  vlrs_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (cmd),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .full     (full)
  );

  vlrs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (empty),
    .term_mode (term_mode),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res       (res)
  );

  assign out_byte      = res.out_byte;
  assign byte_valid    = res.byte_valid;
  assign end_of_output = res.end_of_output;
  assign format_error  = res.format_error;

endmodule

`default_nettype wire

>>> verif/vl_record_to_stream_converter_tb.sv
// Self-checking testbench for the variable-length record to text stream converter.
module vl_record_to_stream_converter_tb;

  localparam int SETTLE_CYCLES = 8;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_byte;
  logic       in_last;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       end_of_output;
  logic       format_error;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_data;

  vl_record_to_stream_converter dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_byte       (in_byte),
    .in_last       (in_last),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .byte_valid    (byte_valid),
    .end_of_output (end_of_output),
    .format_error  (format_error),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  // Predicted deframer state.
  logic [1:0]        model_mode;
  vlrs_pkg::phase_t  cur_phase;
  logic [7:0]        count_low;
  logic [15:0]       data_left;
  logic              odd_count;
  logic              in_record;

  vlrs_pkg::res_t    pending_text[$];
  logic [7:0]        file_q[$];

  int send_idle_pct;
  int recv_idle_pct;
  int bytes_fed;
  int results_checked;
  int mismatches;
  int ragged_files;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic void queue_text(logic [7:0] b, logic bv, logic eo, logic fe);
    vlrs_pkg::res_t r;
    r.out_byte      = b;
    r.byte_valid    = bv;
    r.end_of_output = eo;
    r.format_error  = fe;
    pending_text.push_back(r);
  endfunction

  function automatic void queue_terminator(logic mark_end);
    case (model_mode)
      vlrs_pkg::TERM_LF: queue_text(vlrs_pkg::CHAR_LF, 1'b1, mark_end, 1'b0);
      vlrs_pkg::TERM_CR: queue_text(vlrs_pkg::CHAR_CR, 1'b1, mark_end, 1'b0);
      vlrs_pkg::TERM_CRLF: begin
        queue_text(vlrs_pkg::CHAR_CR, 1'b1, 1'b0, 1'b0);
        queue_text(vlrs_pkg::CHAR_LF, 1'b1, mark_end, 1'b0);
      end
      default: begin
        // With no terminator the end of the stream still needs a bare marker.
        if (mark_end) queue_text(vlrs_pkg::CHAR_NUL, 1'b0, 1'b1, 1'b0);
      end
    endcase
  endfunction

  function automatic void clear_parser();
    cur_phase = vlrs_pkg::PH_LEN_LO;
    count_low = 8'd0;
    data_left = 16'd0;
    odd_count = 1'b0;
    in_record = 1'b0;
  endfunction

  // Works out the text that one accepted file byte produces.
  function automatic void deframe_byte(logic [7:0] b, logic last);
    case (cur_phase)
      vlrs_pkg::PH_LEN_LO: begin
        count_low = b;
        cur_phase = vlrs_pkg::PH_LEN_HI;
      end
      vlrs_pkg::PH_LEN_HI: begin
        data_left = {b, count_low};
        if (in_record) queue_terminator(1'b0);
        in_record = 1'b1;
        odd_count = count_low[0];
        cur_phase = (data_left == 16'd0) ? vlrs_pkg::PH_LEN_LO : vlrs_pkg::PH_DATA;
      end
      vlrs_pkg::PH_DATA: begin
        if (b != vlrs_pkg::CHAR_NUL) queue_text(b, 1'b1, 1'b0, 1'b0);
        data_left = data_left - 16'd1;
        if (data_left == 16'd0) begin
          cur_phase = odd_count ? vlrs_pkg::PH_PAD : vlrs_pkg::PH_LEN_LO;
        end
      end
      default: begin
        odd_count = 1'b0;
        cur_phase = vlrs_pkg::PH_LEN_LO;
      end
    endcase
    if (last) begin
      if (cur_phase == vlrs_pkg::PH_LEN_LO) begin
        queue_terminator(1'b1);
      end else begin
        queue_text(vlrs_pkg::CHAR_NUL, 1'b0, 1'b1, 1'b1);
        ragged_files++;
      end
      clear_parser();
    end
  endfunction

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    vlrs_pkg::res_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_text.size() == 0) begin
        $error("unexpected result: out_byte %02h byte_valid %0b end_of_output %0b format_error %0b",
               out_byte, byte_valid, end_of_output, format_error);
        mismatches++;
      end else begin
        want = pending_text.pop_front();
        results_checked++;
        if (out_byte !== want.out_byte) begin
          $error("out_byte mismatch: expected %02h, got %02h", want.out_byte, out_byte);
          mismatches++;
        end
        if (byte_valid !== want.byte_valid) begin
          $error("byte_valid mismatch: expected %0b, got %0b", want.byte_valid, byte_valid);
          mismatches++;
        end
        if (end_of_output !== want.end_of_output) begin
          $error("end_of_output mismatch: expected %0b, got %0b",
                 want.end_of_output, end_of_output);
          mismatches++;
        end
        if (format_error !== want.format_error) begin
          $error("format_error mismatch: expected %0b, got %0b",
                 want.format_error, format_error);
          mismatches++;
        end
      end
    end
  end

  // Called and returns just after a falling edge, with in_valid low.
  task automatic send_byte(logic [7:0] b, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_byte  = b;
    in_last  = last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    deframe_byte(b, last);
    bytes_fed++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic send_file();
    for (int i = 0; i < file_q.size(); i++) send_byte(file_q[i], i == file_q.size() - 1);
    file_q.delete();
  endtask

  // Holds off new requests until all text is out and the pipeline has emptied.
  task automatic quiesce();
    while (pending_text.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_term_mode(logic [1:0] mode);
    cfg_valid = 1'b1;
    cfg_data  = mode;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    model_mode = mode;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic void push_record(logic [15:0] count);
    file_q.push_back(count[7:0]);
    file_q.push_back(count[15:8]);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(7) == 0) file_q.push_back(vlrs_pkg::CHAR_NUL);
      else file_q.push_back(8'($urandom_range(255)));
    end
    if (count[0]) file_q.push_back(8'($urandom_range(255)));
  endfunction

  function automatic void build_records();
    int roll;
    repeat ($urandom_range(1, 4)) begin
      roll = $urandom_range(99);
      if (roll < 15) push_record(16'd0);
      else if (roll < 75) push_record(16'($urandom_range(1, 6)));
      else push_record(16'($urandom_range(7, 24)));
    end
  endfunction

  task automatic test_clean_records();
    quiesce();
    write_term_mode(vlrs_pkg::TERM_LF);
    // NUL in the data, a pad byte, then a zero-length record closing the file.
    file_q = '{8'h03, 8'h00, 8'h41, 8'h00, 8'h42, 8'hE5, 8'h00, 8'h00};
    send_file();
    quiesce();
    write_term_mode(vlrs_pkg::TERM_CR);
    file_q = '{8'h00, 8'h00};
    send_file();
  endtask

  task automatic test_terminator_modes();
    quiesce();
    write_term_mode(vlrs_pkg::TERM_CRLF);
    file_q = '{8'h01, 8'h00, 8'hFF, 8'h7E};
    send_file();
    quiesce();
    write_term_mode(vlrs_pkg::TERM_NONE);
    file_q = '{8'h02, 8'h00, 8'h80, 8'h01};
    send_file();
  endtask

  task automatic test_ragged_ends();
    quiesce();
    write_term_mode(vlrs_pkg::TERM_LF);
    file_q = '{8'hFF, 8'hFF, 8'h55};
    send_file();
    file_q = '{8'h00};
    send_file();
    // The file stops where the pad byte is due.
    file_q = '{8'h01, 8'h00, 8'h7F};
    send_file();
  endtask

  task automatic test_mode_change_mid_stream();
    quiesce();
    write_term_mode(vlrs_pkg::TERM_CR);
    file_q = '{8'h01, 8'h00, 8'h5A, 8'h00};
    for (int i = 0; i < file_q.size(); i++) send_byte(file_q[i], 1'b0);
    file_q.delete();
    quiesce();
    write_term_mode(vlrs_pkg::TERM_CRLF);
    file_q = '{8'h00, 8'h00};
    send_file();
  endtask

  task automatic test_random_traffic(int send_pct, int recv_pct, int target);
    int first_byte;
    int kind;
    int keep;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    first_byte    = bytes_fed;
    while (bytes_fed - first_byte < target) begin
      if ($urandom_range(2) == 0) begin
        quiesce();
        write_term_mode(2'($urandom_range(3)));
      end
      kind = $urandom_range(99);
      if (kind < 70) begin
        build_records();
      end else if (kind < 85) begin
        build_records();
        if (file_q.size() > 1) begin
          keep   = $urandom_range(1, file_q.size() - 1);
          file_q = file_q[0:keep-1];
        end
      end else begin
        repeat ($urandom_range(1, 6)) file_q.push_back(8'($urandom_range(255)));
      end
      send_file();
    end
  endtask

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    in_byte       = 8'd0;
    in_last       = 1'b0;
    cfg_valid     = 1'b0;
    cfg_data      = vlrs_pkg::TERM_LF;
    send_idle_pct = 28;
    recv_idle_pct = 48;
    model_mode    = vlrs_pkg::TERM_LF;
    clear_parser();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_clean_records();
    test_terminator_modes();
    test_ragged_ends();
    test_mode_change_mid_stream();
    test_random_traffic(28, 48, 70);
    test_random_traffic(48, 28, 70);
    test_random_traffic(0, 0, 70);

    quiesce();
    $display("Fed %0d file bytes and checked %0d text results in all four terminator modes.",
             bytes_fed, results_checked);
    $display("Streams covered clean ends, %0d ragged ends, NUL and pad drops, mode changes.",
             ragged_files);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
